// ===== design/fcpwm_pkg.sv =====
// Shared types, constants and control codes for the fan curve PWM block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fcpwm_pkg;

    // Field widths fixed by the interface
    localparam int TEMP_W   = 12;
    localparam int DEG_W    = 8;
    localparam int PWM_BITS = 10;
    localparam int HOLD_W   = 16;
    localparam int TICK_W   = 17;

    localparam int TEMP_FRAC_BITS_DEF = 4;

    // Rounded temperature, one bit wider than the raw sample
    localparam int T_W      = TEMP_W + 1;
    // Ramp arithmetic: offset (0..254) times drive span
    localparam int MUL_W    = DEG_W + PWM_BITS;
    localparam int DVD_W    = MUL_W + 2;
    localparam int DIVR_W   = DEG_W + 1;
    localparam int REM_W    = DIVR_W + 1;
    localparam int CNT_W    = $clog2(DVD_W);
    localparam int RES_W    = PWM_BITS + 2;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = HOLD_W;
    localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TEMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_PWM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd4;

    // Reset values of the registers
    localparam logic signed [DEG_W-1:0] START_TEMP_RST = 8'sd50;
    localparam logic signed [DEG_W-1:0] FULL_TEMP_RST  = 8'sd70;
    localparam logic [PWM_BITS-1:0]     START_PWM_RST  = 10'd300;
    localparam logic [PWM_BITS-1:0]     MAX_PWM_RST    = 10'd1023;
    localparam logic [HOLD_W-1:0]       HOLD_TICKS_RST = 16'd60;

    // Input item codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [TEMP_W-1:0] temperature;
    } sample_t;

    typedef struct packed {
        logic [PWM_BITS-1:0] pwm;
        logic                fan_on;
    } result_t;

    typedef struct packed {
        logic signed [DEG_W-1:0] start_temp;
        logic signed [DEG_W-1:0] full_temp;
        logic [PWM_BITS-1:0]     start_pwm;
        logic [PWM_BITS-1:0]     max_pwm;
        logic [HOLD_W-1:0]       hold_ticks;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_SCALE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } fcpwm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic round_en;
        logic scale_en;
        logic div_load;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_sample;
        logic in_range;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/fcpwm_cfg.sv =====
// Configuration register file of the fan curve PWM block.
// Depends on fcpwm_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module fcpwm_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fcpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fcpwm_pkg::CFG_DATA_W-1:0] cfg_data,
    output fcpwm_pkg::cfg_regs_t                  regs
);
    import fcpwm_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_TEMP: regs_next.start_temp = cfg_data[DEG_W-1:0];
                REG_FULL_TEMP:  regs_next.full_temp  = cfg_data[DEG_W-1:0];
                REG_START_PWM:  regs_next.start_pwm  = cfg_data[PWM_BITS-1:0];
                REG_MAX_PWM:    regs_next.max_pwm    = cfg_data[PWM_BITS-1:0];
                REG_HOLD_TICKS: regs_next.hold_ticks = cfg_data[HOLD_W-1:0];
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.start_temp <= START_TEMP_RST;
            regs_reg.full_temp  <= FULL_TEMP_RST;
            regs_reg.start_pwm  <= START_PWM_RST;
            regs_reg.max_pwm    <= MAX_PWM_RST;
            regs_reg.hold_ticks <= HOLD_TICKS_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/fcpwm_ctrl.sv =====
// Sequencing state machine of the fan curve PWM block.
// Depends on fcpwm_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module fcpwm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire fcpwm_pkg::dp_status_t status,
    output fcpwm_pkg::ctrl_cmd_t       cmd
);
    import fcpwm_pkg::*;

    fcpwm_state_t state_reg;
    fcpwm_state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid && status.in_is_sample)
                    state_next = ST_ROUND;
            end
            ST_ROUND:  state_next = ST_SCALE;
            ST_SCALE:  state_next = status.in_range ? ST_LOAD : ST_FINISH;
            ST_LOAD:   state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.accept   = sample_valid;
            end
            ST_ROUND:  cmd.round_en = 1'b1;
            ST_SCALE:  cmd.scale_en = 1'b1;
            ST_LOAD:   cmd.div_load = 1'b1;
            ST_DIVIDE: cmd.div_step = 1'b1;
            ST_FINISH: cmd.finish   = status.out_free;
            default:   cmd          = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.in_is_sample) |=> (state_reg == ST_ROUND))
        else $error("accepted sample did not start the rounding step");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && status.div_done) |=> (state_reg == ST_FINISH))
        else $error("divider finished but controller did not move to finish");

    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result written while output register still occupied");

endmodule

`default_nettype wire

// ===== design/fcpwm_dp.sv =====
// Datapath of the fan curve PWM block: rounding, ramp multiply, iterative
// divider, hold logic and output register. Depends on fcpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcpwm_dp #(
    parameter int TEMP_FRAC_BITS = fcpwm_pkg::TEMP_FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fcpwm_pkg::sample_t   sample,
    input  wire fcpwm_pkg::cfg_regs_t regs,
    input  wire fcpwm_pkg::ctrl_cmd_t cmd,
    output fcpwm_pkg::dp_status_t     status,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output fcpwm_pkg::result_t        result
);
    import fcpwm_pkg::*;

    localparam logic [T_W-1:0] HALF = T_W'((1 << TEMP_FRAC_BITS) >> 1);
    localparam logic [TICK_W-1:0] TICK_SAT = {TICK_W{1'b1}};

    // Working registers (no reset)
    logic signed [TEMP_W-1:0] raw_reg;
    logic [T_W-1:0]           t_reg,      t_next;
    logic                     below_reg,  below_next;
    logic                     range_reg,  range_next;
    logic                     neg_reg,    neg_next;
    logic [DEG_W-1:0]         den_reg,    den_next;
    logic [MUL_W-1:0]         mag_reg,    mag_next;
    logic [DVD_W-1:0]         quo_reg,    quo_next;
    logic [REM_W-1:0]         rem_reg,    rem_next;
    logic [CNT_W-1:0]         cnt_reg,    cnt_next;
    result_t                  result_reg, result_next;

    // Control state
    logic                     result_valid_reg, result_valid_next;
    logic [TICK_W-1:0]        since_on_reg,     since_on_next;
    logic [PWM_BITS-1:0]      last_drive_reg,   last_drive_next;

    // Rounding
    logic [T_W-1:0] raw_ext, raw_mag, round_sum, round_q;

    // Ramp setup
    logic [T_W-1:0]             start_ext, full_ext, offset_full;
    logic                       below_c, above_c;
    logic [DIVR_W-1:0]          den_full;
    logic signed [PWM_BITS:0]   span;
    logic [PWM_BITS-1:0]        span_mag;

    // Divider step
    logic [REM_W-1:0] rem_shift, divisor;
    logic             q_bit;

    // Finish
    logic [RES_W-1:0]    res_sum, q_ext, start_pwm_ext;
    logic [PWM_BITS-1:0] ramp_drive, curve_drive, drive;
    logic                hold_active, fan_on;

    assign raw_ext   = {raw_reg[TEMP_W-1], raw_reg};
    assign raw_mag   = raw_reg[TEMP_W-1] ? (T_W'(0) - raw_ext) : raw_ext;
    assign round_sum = raw_mag + HALF;
    assign round_q   = round_sum >> TEMP_FRAC_BITS;

    assign start_ext   = {{(T_W-DEG_W){regs.start_temp[DEG_W-1]}}, regs.start_temp};
    assign full_ext    = {{(T_W-DEG_W){regs.full_temp[DEG_W-1]}}, regs.full_temp};
    assign below_c     = $signed(t_reg) < $signed(start_ext);
    assign above_c     = $signed(t_reg) >= $signed(full_ext);
    assign offset_full = t_reg - start_ext;
    assign den_full    = {regs.full_temp[DEG_W-1], regs.full_temp}
                       - {regs.start_temp[DEG_W-1], regs.start_temp};
    assign span        = $signed({1'b0, regs.max_pwm}) - $signed({1'b0, regs.start_pwm});
    assign span_mag    = span[PWM_BITS] ? PWM_BITS'(-span) : span[PWM_BITS-1:0];

    assign divisor   = REM_W'({den_reg, 1'b0});
    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[DVD_W-1]};
    assign q_bit     = rem_shift >= divisor;

    assign start_pwm_ext = RES_W'(regs.start_pwm);
    assign q_ext         = RES_W'(quo_reg[PWM_BITS:0]);
    assign res_sum       = neg_reg ? (start_pwm_ext - q_ext) : (start_pwm_ext + q_ext);
    assign ramp_drive    = res_sum[RES_W-1] ? '0 : res_sum[PWM_BITS-1:0];
    assign curve_drive   = below_reg ? '0 : (range_reg ? ramp_drive : regs.max_pwm);
    assign hold_active   = since_on_reg <= TICK_W'(regs.hold_ticks);
    assign drive         = (curve_drive == '0 && hold_active) ? regs.start_pwm : curve_drive;
    assign fan_on        = (curve_drive != '0) || hold_active;

    assign status.in_is_sample = (sample.cmd == CMD_SAMPLE);
    assign status.in_range     = !below_c && !above_c;
    assign status.div_done     = (cnt_reg == CNT_W'(DVD_W - 1));
    assign status.out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        t_next      = cmd.round_en ? (raw_reg[TEMP_W-1] ? (T_W'(0) - round_q) : round_q)
                                   : t_reg;
        below_next  = cmd.scale_en ? below_c : below_reg;
        range_next  = cmd.scale_en ? status.in_range : range_reg;
        neg_next    = cmd.scale_en ? span[PWM_BITS] : neg_reg;
        den_next    = cmd.scale_en ? den_full[DEG_W-1:0] : den_reg;
        mag_next    = cmd.scale_en ? (MUL_W'(offset_full[DEG_W-1:0]) * MUL_W'(span_mag))
                                   : mag_reg;

        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cmd.div_load)
        begin
            quo_next = DVD_W'({mag_reg, 1'b0}) + DVD_W'(den_reg);
            rem_next = '0;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[DVD_W-2:0], q_bit};
            rem_next = q_bit ? (rem_shift - divisor) : rem_shift;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        since_on_next     = since_on_reg;
        last_drive_next   = last_drive_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        // Tick: advance and saturate the on-time counter
        if (cmd.accept && sample.cmd == CMD_TICK && since_on_reg != TICK_SAT)
            since_on_next = since_on_reg + TICK_W'(1);
        if (cmd.finish)
        begin
            // Switch-on restarts the minimum on-time
            if (last_drive_reg == '0 && drive != '0)
                since_on_next = '0;
            last_drive_next    = drive;
            result_next.pwm    = drive;
            result_next.fan_on = fan_on;
            result_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            raw_reg <= sample.temperature;
        t_reg      <= t_next;
        below_reg  <= below_next;
        range_reg  <= range_next;
        neg_reg    <= neg_next;
        den_reg    <= den_next;
        mag_reg    <= mag_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            since_on_reg     <= TICK_SAT;
            last_drive_reg   <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            since_on_reg     <= since_on_next;
            last_drive_reg   <= last_drive_next;
        end
    end

    a_drive_implies_on: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.pwm == '0 || result_reg.fan_on))
        else $error("non-zero drive reported with fan off");

    a_switch_on_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && last_drive_reg == '0 && drive != '0) |=> (since_on_reg == '0))
        else $error("switch-on did not restart the on-time counter");

    a_tick_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (since_on_reg == TICK_SAT && !cmd.finish) |=> (since_on_reg == TICK_SAT))
        else $error("saturated on-time counter moved without a result");

endmodule

`default_nettype wire

// ===== design/fan_curve_pwm_with_min_on_time.sv =====
// Fan drive controller with linear fan curve and minimum on-time hold.
// Depends on fcpwm_pkg, fcpwm_cfg, fcpwm_ctrl and fcpwm_dp.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one
//   transaction per temperature sample or one-second tick. A tick only
//   advances the on-time counter and produces no result; the block takes
//   the next transaction in the following cycle.
//   result channel (result_valid / result_stall / result) carries one
//   transaction per temperature sample: the drive value and fan_on.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   five curve registers; cfg_ready is always high. Write only when idle.
// Timing: a sample whose rounded temperature lies on the ramp passes round,
//   scale, load, divide (the 20-step restoring divider) and finish; off the
//   ramp it goes from scale straight to finish. The block takes the next
//   transaction in the cycle after the result is written.
// Reset: registers return to their default curve, the last drive to 0 and
//   the on-time counter to saturated (no hold active).
// Stall: a result waits in the output register while the next transaction
//   is processed; a second result waits in the finish step until the
//   output register drains, holding sample_stall high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module fan_curve_pwm_with_min_on_time #(
    parameter int TEMP_FRAC_BITS = fcpwm_pkg::TEMP_FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    output logic                                  sample_stall,
    input  wire fcpwm_pkg::sample_t               sample,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output fcpwm_pkg::result_t                    result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fcpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fcpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcpwm_pkg::*;

    cfg_regs_t  regs;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Curve registers
    fcpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // Sequencer: accept, round, scale, load, divide, finish
    fcpwm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Arithmetic, hold state and output register
    fcpwm_dp #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .regs         (regs),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
